[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[rtl/tlfs_pkg.sv]
// package: sizes, constants, payload and control types of the scheduler
package tlfs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int SLOT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

  localparam logic [15:0] L1_SLICE = 16'd2;
  localparam logic [7:0] DEMOTED_PRIORITY = 8'd1;
  localparam logic [15:0] QMAX = 16'hFFFF;
  localparam logic [15:0] QUANTUM_RESET = 16'd2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam logic LEVEL_ONE = 1'b0;
  localparam logic LEVEL_TWO = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] proc_id;
    logic [7:0]  proc_priority;
    logic [15:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] ran_id;
    logic        from_level;
    logic [31:0] start_time;
    logic [15:0] run_length;
    logic        finished;
    logic        idle;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic exec;
    logic load_out;
  } tlfs_cmd_t;

  typedef struct packed {
    logic scan_last;
  } tlfs_status_t;

endpackage

[rtl/tlfs_ctrl.sv]
// controller: request sequencing and output handshake
module tlfs_ctrl import tlfs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  tlfs_status_t status,
  output tlfs_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/tlfs_datapath.sv]
// datapath: slot memory, scan trackers, slice arithmetic, time and result registers
module tlfs_datapath import tlfs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tlfs_cmd_t    cmd,
  output tlfs_status_t status,
  input  in_item_t     in_data,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_data,
  output out_item_t    out_data
);

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  priority_num;
    logic [15:0] remaining;
    logic [15:0] quantum;
  } slot_entry_t;

  slot_entry_t slot_mem [MAX_PROCS];
  logic        slot_valid [MAX_PROCS];
  logic        slot_level [MAX_PROCS];

  logic [15:0]       initial_quantum;
  logic [31:0]       time_now;
  in_item_t          req;
  logic [SLOT_W-1:0] cnt;

  slot_entry_t       rd_entry;
  logic              rd_live;
  logic              rd_valid;
  logic              rd_level;
  logic [SLOT_W-1:0] rd_idx;

  logic              free_found;
  logic [SLOT_W-1:0] free_idx;

  logic              b1_found;
  logic [SLOT_W-1:0] b1_idx;
  logic [15:0]       b1_id;
  logic [7:0]        b1_prio;
  logic [15:0]       b1_rem;

  logic              b2_found;
  logic [SLOT_W-1:0] b2_idx;
  logic [15:0]       b2_id;
  logic [15:0]       b2_rem;
  logic [15:0]       b2_quant;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_idx;
  slot_entry_t       wr_entry;
  logic              valid_set;
  logic              valid_clr;
  logic              level_val;
  logic [15:0]       run;
  logic [15:0]       new_rem;
  logic [31:0]       time_next;
  out_item_t         res;
  out_item_t         res_q;

  assign status.scan_last = (cnt == SLOT_W'(MAX_PROCS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_quantum <= QUANTUM_RESET;
    end else if (cfg_we) begin
      initial_quantum <= cfg_data;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      slot_mem[wr_idx] <= wr_entry;
    end
    if (cmd.scan) begin
      rd_entry <= slot_mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PROCS; k++) begin
        slot_valid[k] <= 1'b0;
      end
    end else if (cmd.exec) begin
      if (valid_set) begin
        slot_valid[wr_idx] <= 1'b1;
      end else if (valid_clr) begin
        slot_valid[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      slot_level[wr_idx] <= level_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live <= 1'b0;
    end else begin
      rd_live <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_valid <= slot_valid[cnt];
      rd_level <= slot_level[cnt];
      rd_idx <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start) begin
      cnt <= '0;
    end else if (cmd.scan) begin
      cnt <= cnt + SLOT_W'(1);
    end
  end

  // first free slot and running best of each level, strict compares keep the lowest slot on ties
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      free_found <= 1'b0;
      b1_found <= 1'b0;
      b2_found <= 1'b0;
    end else if (rd_live) begin
      priority if (!rd_valid) begin
        if (!free_found) begin
          free_found <= 1'b1;
          free_idx <= rd_idx;
        end
      end else if (rd_level == LEVEL_ONE) begin
        if (!b1_found || (rd_entry.priority_num < b1_prio)) begin
          b1_found <= 1'b1;
          b1_idx <= rd_idx;
          b1_id <= rd_entry.id;
          b1_prio <= rd_entry.priority_num;
          b1_rem <= rd_entry.remaining;
        end
      end else begin
        if (!b2_found || (rd_entry.remaining > b2_rem)) begin
          b2_found <= 1'b1;
          b2_idx <= rd_idx;
          b2_id <= rd_entry.id;
          b2_rem <= rd_entry.remaining;
          b2_quant <= rd_entry.quantum;
        end
      end
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_idx = '0;
    wr_entry = '0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    level_val = LEVEL_ONE;
    run = '0;
    new_rem = '0;
    time_next = time_now;
    res = '0;
    priority if (req.req_type == REQ_LOAD) begin
      if (free_found) begin
        wr_en = 1'b1;
        wr_idx = free_idx;
        wr_entry.id = req.proc_id;
        wr_entry.priority_num = req.proc_priority;
        wr_entry.remaining = req.burst_length;
        wr_entry.quantum = initial_quantum;
        valid_set = 1'b1;
        level_val = LEVEL_ONE;
        res.accepted = 1'b1;
      end
    end else if (b1_found) begin
      run = (b1_rem < L1_SLICE) ? b1_rem : L1_SLICE;
      new_rem = b1_rem - run;
      time_next = time_now + {16'd0, run};
      wr_idx = b1_idx;
      res.ran_id = b1_id;
      res.from_level = LEVEL_ONE;
      res.start_time = time_now;
      res.run_length = run;
      if (new_rem != 16'd0) begin
        wr_en = 1'b1;
        wr_entry.id = b1_id;
        wr_entry.priority_num = DEMOTED_PRIORITY;
        wr_entry.remaining = new_rem;
        wr_entry.quantum = initial_quantum;
        level_val = LEVEL_TWO;
      end else begin
        valid_clr = 1'b1;
        res.finished = 1'b1;
      end
    end else if (b2_found) begin
      run = (b2_rem < b2_quant) ? b2_rem : b2_quant;
      new_rem = b2_rem - run;
      time_next = time_now + {16'd0, run};
      wr_idx = b2_idx;
      res.ran_id = b2_id;
      res.from_level = LEVEL_TWO;
      res.start_time = time_now;
      res.run_length = run;
      if (new_rem != 16'd0) begin
        wr_en = 1'b1;
        wr_entry.id = b2_id;
        wr_entry.priority_num = DEMOTED_PRIORITY;
        wr_entry.remaining = new_rem;
        wr_entry.quantum = b2_quant[15] ? QMAX : {b2_quant[14:0], 1'b0};
        level_val = LEVEL_ONE;
      end else begin
        valid_clr = 1'b1;
        res.finished = 1'b1;
      end
    end else begin
      res.idle = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if (cmd.exec) begin
      time_now <= time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_q <= res;
    end
    if (cmd.load_out) begin
      out_data <= res_q;
    end
  end

endmodule

[rtl/two_level_feedback_scheduler.sv]
// top level of the two-level feedback scheduler
//
//   channel | signals                       | direction
//   --------+-------------------------------+----------
//   in      | in_valid, in_stall, in_data   | request in
//   out     | out_valid, out_stall, out_data| result out
//   cfg     | cfg_valid, cfg_ready, cfg_data| quantum write in
//
// every request scans all MAX_PROCS slots through the single read port of the
// slot memory, one slot per cycle, then passes the drain, exec and out states
// synchronous reset clears the valid bits at once, no clearing pass
// a stalled result waits in the output register; the next request is taken then
module two_level_feedback_scheduler import tlfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  tlfs_cmd_t    cmd;
  tlfs_status_t status;

  assign cfg_ready = 1'b1;

  tlfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tlfs_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

[rtl/tlfs_checker.sv]
// port-level checker for the scheduler and its bind
`include "assert_macros.svh"

module tlfs_checker import tlfs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_IMPLIES(a_idle_empty, clk, rst, out_valid && out_data.idle, (out_data.run_length == 16'd0) && !out_data.finished && !out_data.accepted)
  `ASSERT_IMPLIES(a_l1_slice, clk, rst, out_valid && !out_data.accepted && !out_data.idle && (out_data.from_level == LEVEL_ONE), out_data.run_length <= L1_SLICE)

endmodule

bind two_level_feedback_scheduler tlfs_checker u_tlfs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
